FILE: src/olae_pkg.sv
`timescale 1ns / 1ps
// Package: sizes, operation and status codes and sequencer states of the ordered list engine.
package olae_pkg;

	localparam int DEPTH  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int POS_W  = 6;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_SEARCH   = 3'd2,
		OP_UPDATE   = 3'd3,
		OP_READ_ALL = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

endpackage

FILE: src/olae_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
module olae_ram #(
	parameter int DEPTH_P = 32,
	parameter int WIDTH   = 32,
	parameter int AW      = $clog2(DEPTH_P)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps
// Ordered list engine: up to 32 signed words kept in order in a RAM, with a count.
// Input channel (in_valid/in_ready) carries op, position and data_word; output channel
// (out_valid/out_ready) carries status, index, element, count and last per result item.
// Insert and update take a position; delete removes the first entry equal to data_word;
// search returns one item per matching entry; read all returns one item per entry.
// Every operation ends with an item that has last set; unused op codes give no item.
// Errors and update load their final item at the accepting edge itself. Insert moves
// m = count - position entries, one per cycle through the RAM, then writes the new word.
// Read all streams one entry per cycle while the receiver takes them. Delete and search
// scan every entry and then report. The next item is taken only once the sequencer is
// back in idle; one item is worked at a time, through the single RAM read and write port.
// A finished result sits in an output register; a new item is taken only once that
// register is free or being emptied. A stalled receiver pauses the stream in place.
// Reset (arst_n low) empties the list and drops any pending result; the RAM is not
// cleared, as only entries below the count are ever read.
module ordered_array_list_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     op,
	input  logic [olae_pkg::POS_W-1:0]     position,
	input  logic signed [olae_pkg::WORD_W-1:0] data_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [4:0]                     index,
	output logic signed [olae_pkg::WORD_W-1:0] element,
	output logic [5:0]                     count,
	output logic                           last
);

	localparam int AW = olae_pkg::ADDR_W;
	localparam int CW = olae_pkg::CNT_W;
	localparam int WW = olae_pkg::WORD_W;

	olae_pkg::state_t state_q, state_d;
	olae_pkg::op_t    opr_q, opr_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    ra_q, ra_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [WW-1:0]    key_q, key_d;
	logic             pend_s1, pend_d;
	logic [AW-1:0]    di_s1, di_d;
	logic             found_q, found_d;
	logic [AW-1:0]    hit_q, hit_d;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [4:0]       index_q;
	logic [WW-1:0]    element_q;
	logic [5:0]       count_out_q;
	logic             last_q;

	logic             out_load;
	olae_pkg::status_t ld_status;
	logic [AW-1:0]    ld_index;
	logic [WW-1:0]    ld_elem;
	logic [CW-1:0]    ld_count;
	logic             ld_last;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [WW-1:0]    ram_wdata, ram_rdata;

	logic             out_free, match, needs_emit, can_consume;

	olae_ram #(
		.DEPTH_P(olae_pkg::DEPTH),
		.WIDTH  (WW),
		.AW     (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !out_valid_q || out_ready;
	assign match    = (ram_rdata == key_q);

	always_comb begin
		state_d   = state_q;
		opr_d     = opr_q;
		count_d   = count_q;
		ra_d      = ra_q;
		pos_d     = pos_q;
		key_d     = key_q;
		pend_d    = pend_s1;
		di_d      = di_s1;
		found_d   = found_q;
		hit_d     = hit_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		out_load  = 1'b0;
		ld_status = olae_pkg::ST_OK;
		ld_index  = '0;
		ld_elem   = '0;
		ld_count  = count_q;
		ld_last   = 1'b1;
		needs_emit  = 1'b0;
		can_consume = 1'b1;

		case (state_q)
			olae_pkg::S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					key_d   = data_word;
					pos_d   = CW'(position);
					found_d = 1'b0;
					pend_d  = 1'b0;
					ra_d    = '0;
					opr_d   = olae_pkg::op_t'(op);
					case (olae_pkg::op_t'(op))
						olae_pkg::OP_INSERT: begin
							if (count_q >= CW'(olae_pkg::DEPTH)) begin
								out_load  = 1'b1;
								ld_status = olae_pkg::ST_FULL;
							end else if (CW'(position) > count_q) begin
								out_load  = 1'b1;
								ld_status = olae_pkg::ST_BAD_POS;
							end else begin
								ra_d    = count_q;
								state_d = olae_pkg::S_SHIFT;
							end
						end
						olae_pkg::OP_DELETE, olae_pkg::OP_SEARCH,
						olae_pkg::OP_READ_ALL: begin
							if (count_q == '0) begin
								out_load  = 1'b1;
								ld_status = olae_pkg::ST_EMPTY;
							end else begin
								state_d = olae_pkg::S_SCAN;
							end
						end
						olae_pkg::OP_UPDATE: begin
							if (count_q == '0) begin
								out_load  = 1'b1;
								ld_status = olae_pkg::ST_EMPTY;
							end else if (CW'(position) >= count_q) begin
								out_load  = 1'b1;
								ld_status = olae_pkg::ST_BAD_POS;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = position[AW-1:0];
								ram_wdata = data_word;
								out_load  = 1'b1;
								ld_index  = position[AW-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end

			olae_pkg::S_SCAN: begin
				case (opr_q)
					olae_pkg::OP_READ_ALL: needs_emit = 1'b1;
					olae_pkg::OP_SEARCH:   needs_emit = match && found_q;
					default:               needs_emit = 1'b0;
				endcase
				can_consume = !pend_s1 || !needs_emit || out_free;

				if (pend_s1 && can_consume) begin
					case (opr_q)
						olae_pkg::OP_DELETE: begin
							if (found_q) begin
								// close the gap left by the removed entry
								ram_we    = 1'b1;
								ram_waddr = di_s1 - AW'(1);
								ram_wdata = ram_rdata;
							end else if (match) begin
								found_d = 1'b1;
								hit_d   = di_s1;
							end
						end
						olae_pkg::OP_SEARCH: begin
							// a match is held back until it is known whether it is the last
							if (match) begin
								if (found_q) begin
									out_load = 1'b1;
									ld_index = hit_q;
									ld_elem  = key_q;
									ld_last  = 1'b0;
								end
								found_d = 1'b1;
								hit_d   = di_s1;
							end
						end
						default: begin
							out_load = 1'b1;
							ld_index = di_s1;
							ld_elem  = ram_rdata;
							ld_last  = ((CW'(di_s1) + CW'(1)) == count_q);
						end
					endcase
				end

				if (ra_q < count_q && can_consume) begin
					ram_re    = 1'b1;
					ram_raddr = ra_q[AW-1:0];
					ra_d      = ra_q + CW'(1);
					di_d      = ra_q[AW-1:0];
					pend_d    = 1'b1;
				end else if (can_consume) begin
					pend_d = 1'b0;
				end

				if (!pend_s1 && ra_q == count_q) begin
					if (opr_q == olae_pkg::OP_READ_ALL) begin
						state_d = olae_pkg::S_IDLE;
					end else begin
						state_d = olae_pkg::S_FINISH;
					end
				end
			end

			olae_pkg::S_SHIFT: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = di_s1;
					ram_wdata = ram_rdata;
				end
				if (ra_q > pos_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(ra_q - CW'(1));
					di_d      = ra_q[AW-1:0];
					ra_d      = ra_q - CW'(1);
					pend_d    = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_s1 && out_free) begin
						ram_we    = 1'b1;
						ram_waddr = pos_q[AW-1:0];
						ram_wdata = key_q;
						count_d   = count_q + CW'(1);
						out_load  = 1'b1;
						ld_index  = pos_q[AW-1:0];
						ld_count  = count_q + CW'(1);
						state_d   = olae_pkg::S_IDLE;
					end
				end
			end

			olae_pkg::S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = olae_pkg::S_IDLE;
					if (!found_q) begin
						ld_status = olae_pkg::ST_NOT_FOUND;
					end else if (opr_q == olae_pkg::OP_DELETE) begin
						ld_index = hit_q;
						count_d  = count_q - CW'(1);
						ld_count = count_q - CW'(1);
					end else begin
						ld_index = hit_q;
						ld_elem  = key_q;
					end
				end
			end

			default: begin
				state_d = olae_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olae_pkg::S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= pend_d;
			found_q <= found_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		opr_q <= opr_d;
		ra_q  <= ra_d;
		pos_q <= pos_d;
		key_q <= key_d;
		di_s1 <= di_d;
		hit_q <= hit_d;
		if (out_load) begin
			status_q    <= ld_status;
			index_q     <= 5'(ld_index);
			element_q   <= ld_elem;
			count_out_q <= 6'(ld_count);
			last_q      <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign element   = element_q;
	assign count     = count_out_q;
	assign last      = last_q;

endmodule

FILE: tb/ordered_array_list_engine_unit_checker.sv
`timescale 1ns / 1ps
// Checker: shadow list, queue of expected result items and field-by-field comparison.
module ordered_array_list_engine_unit_checker (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	input  logic                                              in_ready,
	input  logic [2:0]                                        op,
	input  logic [olae_pkg::POS_W-1:0]                        position,
	input  logic signed [olae_pkg::WORD_W-1:0]                data_word,
	input  logic                                              out_valid,
	input  logic                                              out_ready,
	input  logic [2:0]                                        status,
	input  logic [4:0]                                        index,
	input  logic signed [olae_pkg::WORD_W-1:0]                element,
	input  logic [5:0]                                        count,
	input  logic                                              last,
	output logic [olae_pkg::CNT_W-1:0]                        list_len,
	output logic [olae_pkg::DEPTH-1:0][olae_pkg::WORD_W-1:0]  list_words,
	output int                                                outstanding,
	output int                                                error_count,
	output int                                                results_checked
);

	typedef struct {
		olae_pkg::status_t   status;
		logic [4:0]          index;
		logic signed [31:0]  element;
		logic [5:0]          count;
		logic                last;
	} list_result_t;

	list_result_t                         pending_results[$];
	list_result_t                         oldest;
	logic signed [olae_pkg::WORD_W-1:0]   shadow_words [olae_pkg::DEPTH];
	logic [olae_pkg::CNT_W-1:0]           shadow_len;
	int                                   fail_tally;
	int                                   seen_tally;

	task automatic push_result(input olae_pkg::status_t st, input logic [4:0] idx,
			input logic signed [olae_pkg::WORD_W-1:0] elem, input logic fin);
		list_result_t r;
		r.status  = st;
		r.index   = idx;
		r.element = elem;
		r.count   = 6'(shadow_len);
		r.last    = fin;
		pending_results.push_back(r);
	endtask

	task automatic predict_list_op(input logic [2:0] opc,
			input logic [olae_pkg::POS_W-1:0] pos,
			input logic signed [olae_pkg::WORD_W-1:0] word);
		int i;
		int found;
		int hits;
		int k;
		found = -1;
		hits  = 0;
		k     = 0;
		case (opc)
			olae_pkg::OP_INSERT: begin
				if (shadow_len >= olae_pkg::DEPTH) begin
					push_result(olae_pkg::ST_FULL, '0, '0, 1'b1);
				end else if (pos > shadow_len) begin
					push_result(olae_pkg::ST_BAD_POS, '0, '0, 1'b1);
				end else begin
					for (i = int'(shadow_len); i > int'(pos); i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = word;
					shadow_len = shadow_len + 1'b1;
					push_result(olae_pkg::ST_OK, pos[4:0], '0, 1'b1);
				end
			end
			olae_pkg::OP_DELETE: begin
				if (shadow_len == 0) begin
					push_result(olae_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < int'(shadow_len); i++)
						if (found < 0 && shadow_words[i] == word)
							found = i;
					if (found < 0) begin
						push_result(olae_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
					end else begin
						for (i = found; i + 1 < int'(shadow_len); i++)
							shadow_words[i] = shadow_words[i+1];
						shadow_len = shadow_len - 1'b1;
						push_result(olae_pkg::ST_OK, 5'(found), '0, 1'b1);
					end
				end
			end
			olae_pkg::OP_SEARCH: begin
				if (shadow_len == 0) begin
					push_result(olae_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < int'(shadow_len); i++)
						if (shadow_words[i] == word)
							hits++;
					if (hits == 0) begin
						push_result(olae_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
					end else begin
						for (i = 0; i < int'(shadow_len); i++) begin
							if (shadow_words[i] == word) begin
								push_result(olae_pkg::ST_OK, 5'(i), shadow_words[i],
									k == hits - 1);
								k++;
							end
						end
					end
				end
			end
			olae_pkg::OP_UPDATE: begin
				if (shadow_len == 0) begin
					push_result(olae_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else if (pos >= shadow_len) begin
					push_result(olae_pkg::ST_BAD_POS, '0, '0, 1'b1);
				end else begin
					shadow_words[pos] = word;
					push_result(olae_pkg::ST_OK, pos[4:0], '0, 1'b1);
				end
			end
			olae_pkg::OP_READ_ALL: begin
				if (shadow_len == 0) begin
					push_result(olae_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < int'(shadow_len); i++)
						push_result(olae_pkg::ST_OK, 5'(i), shadow_words[i],
							i + 1 == int'(shadow_len));
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = '0;
			pending_results.delete();
			fail_tally = 0;
			seen_tally = 0;
		end else begin
			// drain before predicting: a result never belongs to an item taken this edge
			if (out_valid && out_ready) begin
				seen_tally++;
				if (pending_results.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display({"%0t: unexpected result item: status %0d index %0d",
							" element %0d count %0d last %0d"},
							$realtime, status, index, element, count, last);
				end else begin
					oldest = pending_results.pop_front();
					if (status !== oldest.status || index !== oldest.index ||
							element !== oldest.element || count !== oldest.count ||
							last !== oldest.last) begin
						fail_tally++;
						if (fail_tally <= 10) begin
							$display({"%0t: mismatch: exp status %0d index %0d",
								" element %0d count %0d last %0d"},
								$realtime, oldest.status, oldest.index, oldest.element,
								oldest.count, oldest.last);
							$display({"%0t:           got status %0d index %0d",
								" element %0d count %0d last %0d"},
								$realtime, status, index, element, count, last);
						end
					end
				end
			end
			if (in_valid && in_ready)
				predict_list_op(op, position, data_word);
		end
		list_len        <= shadow_len;
		outstanding     <= pending_results.size();
		error_count     <= fail_tally;
		results_checked <= seen_tally;
		for (int w = 0; w < olae_pkg::DEPTH; w++)
			list_words[w] <= shadow_words[w];
	end

endmodule

FILE: tb/ordered_array_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, list operation stimulus, receiver stalls and the verdict.
module ordered_array_list_engine_unit_tb;

	localparam int RUN_LIMIT  = 1000000;
	localparam int RANDOM_OPS = 100;
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	logic                                             clk       = 1'b0;
	logic                                             arst_n    = 1'b0;
	logic                                             in_valid  = 1'b0;
	logic                                             in_ready;
	logic [2:0]                                       op        = '0;
	logic [olae_pkg::POS_W-1:0]                       position  = '0;
	logic signed [olae_pkg::WORD_W-1:0]               data_word = '0;
	logic                                             out_valid;
	logic                                             out_ready = 1'b0;
	logic [2:0]                                       status;
	logic [4:0]                                       index;
	logic signed [olae_pkg::WORD_W-1:0]               element;
	logic [5:0]                                       count;
	logic                                             last;

	logic [olae_pkg::CNT_W-1:0]                       list_len;
	logic [olae_pkg::DEPTH-1:0][olae_pkg::WORD_W-1:0] list_words;
	int                                               outstanding;
	int                                               error_count;
	int                                               results_checked;

	int cycle_count = 0;
	int ops_sent    = 0;
	int unused_sent = 0;
	int burst_left  = 0;
	int stall_left  = 0;
	int calm_left   = 0;
	int ready_roll;

	ordered_array_list_engine_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .position(position), .data_word(data_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .index(index), .element(element), .count(count), .last(last)
	);

	ordered_array_list_engine_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .position(position), .data_word(data_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .index(index), .element(element), .count(count), .last(last),
		.list_len(list_len), .list_words(list_words), .outstanding(outstanding),
		.error_count(error_count), .results_checked(results_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d result items still pending",
				cycle_count, outstanding);
			$display("ordered_array_list_engine_unit test failed");
			$finish;
		end
	end

	// receiver: mostly ready, short and long stalls, occasional stall-free stretches
	always @(posedge clk) begin
		if (calm_left > 0) begin
			calm_left <= calm_left - 1;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 2) begin
				calm_left <= $urandom_range(60, 150);
				out_ready <= 1'b1;
			end else if (ready_roll < 68) begin
				out_ready <= 1'b1;
			end else if (ready_roll < 95) begin
				stall_left <= $urandom_range(0, 3);
				out_ready  <= 1'b0;
			end else begin
				stall_left <= $urandom_range(15, 50);
				out_ready  <= 1'b0;
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(8, 16);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic signed [olae_pkg::WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return olae_pkg::WORD_W'(int'($urandom_range(0, 6)) - 3);
		if (r < 58) begin
			case ($urandom_range(0, 3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7fff_ffff;
				2:       return '0;
				default: return -32'sd1;
			endcase
		end
		return $urandom();
	endfunction

	task automatic send_op(input logic [2:0] opc, input logic [olae_pkg::POS_W-1:0] pos,
			input logic signed [olae_pkg::WORD_W-1:0] word);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= opc;
		position  <= pos;
		data_word <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (opc <= olae_pkg::OP_READ_ALL)
			ops_sent++;
		else
			unused_sent++;
	endtask

	initial begin
		int                                  directed_ops;
		int                                  len;
		int                                  r;
		int                                  full_hits;
		bit                                  grow;
		logic [2:0]                          opc;
		logic [olae_pkg::POS_W-1:0]          pos;
		logic signed [olae_pkg::WORD_W-1:0]  word;

		full_hits = 0;
		grow      = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bad positions, extremes, duplicates, unused codes
		send_op(olae_pkg::OP_READ_ALL, '0, '0);
		send_op(olae_pkg::OP_DELETE, '0, 32'sd5);
		send_op(olae_pkg::OP_SEARCH, '0, 32'sd5);
		send_op(olae_pkg::OP_UPDATE, '0, 32'sd5);
		send_op(olae_pkg::OP_INSERT, 6'd1, 32'sd9);
		send_op(olae_pkg::OP_INSERT, 6'd0, 32'sh8000_0000);
		send_op(olae_pkg::OP_INSERT, 6'd1, 32'sh7fff_ffff);
		send_op(olae_pkg::OP_INSERT, 6'd0, -32'sd1);
		send_op(olae_pkg::OP_INSERT, 6'd63, 32'sd1);
		send_op(olae_pkg::OP_INSERT, 6'd4, 32'sd1);
		send_op(olae_pkg::OP_INSERT, 6'd3, 32'sd7);
		send_op(olae_pkg::OP_INSERT, 6'd2, 32'sd7);
		send_op(olae_pkg::OP_UPDATE, 6'd5, 32'sd3);
		send_op(olae_pkg::OP_UPDATE, 6'd63, 32'sd3);
		send_op(olae_pkg::OP_UPDATE, 6'd1, 32'sd7);
		send_op(olae_pkg::OP_SEARCH, '0, 32'sd7);
		send_op(olae_pkg::OP_SEARCH, '0, 32'sd12345);
		send_op(olae_pkg::OP_SEARCH, '0, 32'sh7fff_ffff);
		send_op(olae_pkg::OP_DELETE, '0, 32'sd12345);
		send_op(olae_pkg::OP_DELETE, '0, 32'sd7);
		send_op(olae_pkg::OP_DELETE, '0, -32'sd1);
		send_op(olae_pkg::OP_READ_ALL, '0, '0);
		send_op(OP_UNUSED_LO, 6'd0, 32'sd7);
		send_op(OP_UNUSED_MID, 6'd63, -32'sd1);
		send_op(OP_UNUSED_HI, 6'd1, 32'sh8000_0000);
		send_op(olae_pkg::OP_UPDATE, 6'd0, 32'sh5555_aaaa);
		send_op(olae_pkg::OP_READ_ALL, '0, '0);
		directed_ops = ops_sent;

		// random: grow and shrink phases so the list goes between empty and full
		while (ops_sent - directed_ops < RANDOM_OPS) begin
			len = int'(list_len);
			if (len >= olae_pkg::DEPTH && grow) begin
				grow = 1'b0;
				full_hits++;
			end else if (len == 0) begin
				grow = 1'b1;
			end else if ($urandom_range(0, 39) == 0) begin
				grow = !grow;
			end
			r    = $urandom_range(0, 99);
			pos  = '0;
			word = pick_word();
			if (r < 5) begin
				opc  = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				pos  = 6'($urandom_range(0, 63));
				word = $urandom();
			end else if (r < 13) begin
				opc  = 3'($urandom_range(0, olae_pkg::OP_READ_ALL));
				pos  = 6'($urandom_range(0, 63));
				word = $urandom();
			end else begin
				r = $urandom_range(0, 99);
				if (grow)
					opc = (r < 50) ? olae_pkg::OP_INSERT :
						(r < 62) ? olae_pkg::OP_DELETE :
						(r < 74) ? olae_pkg::OP_SEARCH :
						(r < 87) ? olae_pkg::OP_UPDATE : olae_pkg::OP_READ_ALL;
				else
					opc = (r < 12) ? olae_pkg::OP_INSERT :
						(r < 52) ? olae_pkg::OP_DELETE :
						(r < 68) ? olae_pkg::OP_SEARCH :
						(r < 84) ? olae_pkg::OP_UPDATE : olae_pkg::OP_READ_ALL;
				case (opc)
					olae_pkg::OP_INSERT:
						pos = 6'($urandom_range(0, len));
					olae_pkg::OP_UPDATE:
						pos = (len > 0) ? 6'($urandom_range(0, len - 1)) : '0;
					olae_pkg::OP_DELETE, olae_pkg::OP_SEARCH:
						if (len > 0 && $urandom_range(0, 3) != 0)
							word = $signed(list_words[$urandom_range(0, len - 1)]);
					default: begin
					end
				endcase
			end
			send_op(opc, pos, word);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d list operations and %0d unused codes, %0d results checked.",
			ops_sent, unused_sent, results_checked);
		$display("List reached capacity %0d times; %0d mismatches in %0d cycles.",
			full_hits, error_count, cycle_count);
		if (error_count == 0)
			$display("ordered_array_list_engine_unit test passed");
		else
			$display("ordered_array_list_engine_unit test failed");
		$finish;
	end

endmodule
